// File: rtl/core/f2d_pkg.sv
// Shared types and constants for the two-dimensional Fenwick tree block.
package f2d_pkg;

  localparam int COORD_W = 7;   // coordinate and grid size fields
  localparam int IDX_W   = 8;   // walk index: holds a coordinate plus one climb step
  localparam int VALUE_W = 64;  // tree cell width
  localparam int ADD_W   = 32;  // add amount width

  localparam logic CMD_QUERY = 1'b0;
  localparam logic CMD_ADD   = 1'b1;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CORNER,
    ST_ROW,
    ST_CELL,
    ST_UPDATE
  } state_t;

  // Lowest set bit of a walk index.
  function automatic logic [IDX_W-1:0] low_bit(input logic [IDX_W-1:0] x);
    return x & (~x + 1'b1);
  endfunction

endpackage

// File: rtl/core/fenwick_2d_range_add_point_query.sv
// Two-dimensional Fenwick tree with rectangle add and point query.
// A point query descends from the point through rows (outer) and columns (inner), at most 7 of
// each at 64 x 64; a range add climbs likewise from each of its four corners in turn. Each cell
// visit is a read and then an update through one shared 64-bit adder.
// Throughput: one item at a time, busy high until the walk ends; a rejected item answers in the
// next cycle; no receiver stall. Reset (sync): clears MAX_ROWS*MAX_COLS cells, one per cycle.
module fenwick_2d_range_add_point_query #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // command channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 command,
  input  logic [f2d_pkg::COORD_W-1:0]          row_low,
  input  logic [f2d_pkg::COORD_W-1:0]          col_low,
  input  logic [f2d_pkg::COORD_W-1:0]          row_high,
  input  logic [f2d_pkg::COORD_W-1:0]          col_high,
  input  logic signed [f2d_pkg::ADD_W-1:0]     add_value,
  // result channel: one-cycle strobe, cannot be held off
  output logic                                 done,
  output logic signed [f2d_pkg::VALUE_W-1:0]   point_value,
  output logic                                 range_error,
  // configuration port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [2:0]                           paddr,
  input  logic [31:0]                          pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  import f2d_pkg::*;

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);

  // Configuration registers.
  logic [COORD_W-1:0] rows_in_use;
  logic [COORD_W-1:0] cols_in_use;
  logic               cfg_write;
  logic [COORD_W-1:0] rows_act;
  logic [COORD_W-1:0] cols_act;

  // Sequencer state and the walk registers.
  state_t             state, state_next;
  logic [AW-1:0]      clr_addr, clr_addr_next;
  logic               cmd_query, cmd_query_next;
  logic [COORD_W-1:0] rl, rl_next;
  logic [COORD_W-1:0] cl, cl_next;
  logic [IDX_W-1:0]   rh1, rh1_next;   // high row plus one
  logic [IDX_W-1:0]   ch1, ch1_next;   // high column plus one
  logic [VALUE_W-1:0] val, val_next;   // sign-extended add amount
  logic [1:0]         corner, corner_next;
  logic [IDX_W-1:0]   i_idx, i_idx_next;
  logic [IDX_W-1:0]   j_idx, j_idx_next;
  logic [IDX_W-1:0]   j_start, j_start_next;
  logic [AW-1:0]      row_base, row_base_next;
  logic [AW-1:0]      cell_addr, cell_addr_next;
  // Second operand of the shared adder: running sum for a query, cell delta for an add.
  logic [VALUE_W-1:0] addend, addend_next;
  logic               done_next;
  logic [VALUE_W-1:0] point_value_next;
  logic               range_error_next;

  // Tree memory.
  logic [VALUE_W-1:0] tree_mem [DEPTH];
  logic [VALUE_W-1:0] rdata;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;

  logic               accept;
  logic               q_ok;
  logic               a_ok;
  logic [VALUE_W-1:0] sum;

  // ---------------------------------------------------------------------------
  // Configuration port: always ready, register index in paddr[2].
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= COORD_W'(64);
      cols_in_use <= COORD_W'(64);
    end else if (cfg_write) begin
      case (paddr[2])
        REG_ROWS: rows_in_use <= pwdata[COORD_W-1:0];
        REG_COLS: cols_in_use <= pwdata[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_ROWS: prdata = {{(32-COORD_W){1'b0}}, rows_in_use};
      REG_COLS: prdata = {{(32-COORD_W){1'b0}}, cols_in_use};
      default:  prdata = '0;
    endcase
  end

  // Grid in use: a register above the parameter is clipped to it.
  assign rows_act = (32'(rows_in_use) > MAX_ROWS) ? COORD_W'(MAX_ROWS) : rows_in_use;
  assign cols_act = (32'(cols_in_use) > MAX_COLS) ? COORD_W'(MAX_COLS) : cols_in_use;

  // ---------------------------------------------------------------------------
  // Command checks, evaluated on the ports while idle.
  // ---------------------------------------------------------------------------
  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign q_ok = (row_low != '0) && (row_low <= rows_act) &&
                (col_low != '0) && (col_low <= cols_act);
  assign a_ok = (row_low != '0) && (col_low != '0) &&
                (row_low <= row_high) && (col_low <= col_high) &&
                (row_high <= rows_act) && (col_high <= cols_act);

  // The shared 64-bit adder: every cell visit goes through it.
  assign sum = rdata + addend;

  // ---------------------------------------------------------------------------
  // Sequencer: clear pass, then per item walk rows (outer) and columns (inner).
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= clr_addr_next;
      done     <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_query   <= cmd_query_next;
    rl          <= rl_next;
    cl          <= cl_next;
    rh1         <= rh1_next;
    ch1         <= ch1_next;
    val         <= val_next;
    corner      <= corner_next;
    i_idx       <= i_idx_next;
    j_idx       <= j_idx_next;
    j_start     <= j_start_next;
    row_base    <= row_base_next;
    cell_addr   <= cell_addr_next;
    addend      <= addend_next;
    point_value <= point_value_next;
    range_error <= range_error_next;
  end

  always_comb begin
    state_next       = state;
    clr_addr_next    = clr_addr;
    cmd_query_next   = cmd_query;
    rl_next          = rl;
    cl_next          = cl;
    rh1_next         = rh1;
    ch1_next         = ch1;
    val_next         = val;
    corner_next      = corner;
    i_idx_next       = i_idx;
    j_idx_next       = j_idx;
    j_start_next     = j_start;
    row_base_next    = row_base;
    cell_addr_next   = cell_addr;
    addend_next      = addend;
    done_next        = 1'b0;
    point_value_next = point_value;
    range_error_next = range_error;
    mem_we           = 1'b0;
    mem_waddr        = cell_addr;
    mem_wdata        = sum;
    mem_re           = 1'b0;
    mem_raddr        = row_base + AW'(j_idx - 1'b1);

    case (state)
      ST_CLEAR: begin
        // Zero one cell a cycle.
        mem_we        = 1'b1;
        mem_waddr     = clr_addr;
        mem_wdata     = '0;
        clr_addr_next = clr_addr + 1'b1;
        if (clr_addr == AW'(DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          cmd_query_next = (command == CMD_QUERY);
          rl_next        = row_low;
          cl_next        = col_low;
          rh1_next       = {1'b0, row_high} + 1'b1;
          ch1_next       = {1'b0, col_high} + 1'b1;
          val_next       = VALUE_W'(add_value);
          corner_next    = '0;
          if (command == CMD_QUERY) begin
            if (q_ok) begin
              i_idx_next   = {1'b0, row_low};
              j_start_next = {1'b0, col_low};
              addend_next  = '0;
              state_next   = ST_ROW;
            end else begin
              // Bad point: report at once.
              done_next        = 1'b1;
              point_value_next = '0;
              range_error_next = 1'b1;
            end
          end else begin
            if (a_ok) begin
              state_next = ST_CORNER;
            end else begin
              // Bad rectangle: report at once, touch nothing.
              done_next        = 1'b1;
              point_value_next = '0;
              range_error_next = 1'b1;
            end
          end
        end
      end

      ST_CORNER: begin
        // Corners in order: (low,low)+, (low,high+1)-, (high+1,low)-, (high+1,high+1)+.
        case (corner)
          2'd0: begin
            i_idx_next   = {1'b0, rl};
            j_start_next = {1'b0, cl};
          end
          2'd1: begin
            i_idx_next   = {1'b0, rl};
            j_start_next = ch1;
          end
          2'd2: begin
            i_idx_next   = rh1;
            j_start_next = {1'b0, cl};
          end
          default: begin
            i_idx_next   = rh1;
            j_start_next = ch1;
          end
        endcase
        addend_next = (corner[0] ^ corner[1]) ? (~val + 1'b1) : val;
        state_next  = ST_ROW;
      end

      ST_ROW: begin
        if (cmd_query ? (i_idx != '0) : (i_idx <= {1'b0, rows_act})) begin
          row_base_next = AW'(i_idx - 1'b1) * AW'(MAX_COLS);
          j_idx_next    = j_start;
          state_next    = ST_CELL;
        end else if (cmd_query) begin
          // Descent finished: deliver the running sum.
          done_next        = 1'b1;
          point_value_next = addend;
          range_error_next = 1'b0;
          state_next       = ST_IDLE;
        end else if (corner == 2'd3) begin
          state_next = ST_IDLE;
        end else begin
          corner_next = corner + 1'b1;
          state_next  = ST_CORNER;
        end
      end

      ST_CELL: begin
        if (cmd_query ? (j_idx != '0) : (j_idx <= {1'b0, cols_act})) begin
          // Issue the read; hold the address for the write back.
          mem_re         = 1'b1;
          cell_addr_next = mem_raddr;
          state_next     = ST_UPDATE;
        end else begin
          // Column walk done: step the row.
          i_idx_next = cmd_query ? (i_idx - low_bit(i_idx)) : (i_idx + low_bit(i_idx));
          state_next = ST_ROW;
        end
      end

      ST_UPDATE: begin
        if (cmd_query) begin
          addend_next = sum;
        end else begin
          mem_we = 1'b1;
        end
        j_idx_next = cmd_query ? (j_idx - low_bit(j_idx)) : (j_idx + low_bit(j_idx));
        state_next = ST_CELL;
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Single-port tree memory, registered read.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tree_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= tree_mem[mem_raddr];
    end
  end

`ifndef SYNTH
  // A bad query point is reported in the next cycle with the error flag.
  a_bad_query: assert property (@(posedge clk) disable iff (rst)
    (accept && command == CMD_QUERY && !q_ok) |=> (done && range_error))
    else $error("bad query point not reported");

  // A result is only delivered when the block is free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  // Every cell update uses data read in the cycle before.
  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    (state == ST_UPDATE) |-> ($past(state) == ST_CELL))
    else $error("cell update without a preceding read");
`endif

endmodule

// File: bench/fenwick_2d_range_add_point_query_test.sv
// Self-checking bench for the 2-D Fenwick tree: rectangle adds and point queries.
`timescale 1ns / 1ps

module fenwick_2d_range_add_point_query_test;
  import f2d_pkg::*;

  localparam int MAX_R = 64;
  localparam int MAX_C = 64;
  // Wait for the longest range add at 64 x 64 to finish, with some margin.
  localparam int LATENCY_PAUSE = 600;
  // Reset clearing plus ~1700 items at their slowest, several times over.
  localparam int CYCLE_LIMIT = 4000000;
  localparam int NUM_PHASES = 7;

  // Golden model of the tree plus the queue of results still owed by the block.
  class grid_ledger;
    typedef struct packed {
      logic [VALUE_W-1:0] sum;
      logic               err;
    } point_result_t;

    logic [VALUE_W-1:0] cells [MAX_R*MAX_C];
    logic [COORD_W-1:0] rows_reg;
    logic [COORD_W-1:0] cols_reg;
    point_result_t      pending [$];
    int                 fails;

    function new();
      foreach (cells[k]) cells[k] = '0;
      rows_reg = 7'd64;
      cols_reg = 7'd64;
      fails = 0;
    endfunction

    function void set_grid(logic idx, logic [COORD_W-1:0] val);
      if (idx == REG_ROWS) rows_reg = val;
      else cols_reg = val;
    endfunction

    function int rows_eff();
      return (int'(rows_reg) < MAX_R) ? int'(rows_reg) : MAX_R;
    endfunction

    function int cols_eff();
      return (int'(cols_reg) < MAX_C) ? int'(cols_reg) : MAX_C;
    endfunction

    // Climb from (r, c) by lowest set bit, adding v to every cell passed.
    function void climb_add(int r, int c, logic [VALUE_W-1:0] v);
      int i;
      int j;
      int nr;
      int nc;
      nr = rows_eff();
      nc = cols_eff();
      for (i = r; i >= 1 && i <= nr; i += i & -i)
        for (j = c; j >= 1 && j <= nc; j += j & -j)
          cells[(i-1)*MAX_C + (j-1)] += v;
    endfunction

    // Descend from (r, c) summing the cells visited: the value at that point.
    function logic [VALUE_W-1:0] descend_sum(int r, int c);
      logic [VALUE_W-1:0] s;
      int i;
      int j;
      s = '0;
      for (i = r; i > 0; i -= i & -i)
        for (j = c; j > 0; j -= j & -j)
          s += cells[(i-1)*MAX_C + (j-1)];
      return s;
    endfunction

    function void take_item(logic cmd, logic [COORD_W-1:0] rl, logic [COORD_W-1:0] cl,
                            logic [COORD_W-1:0] rh, logic [COORD_W-1:0] ch,
                            logic [ADD_W-1:0] v);
      point_result_t res;
      logic [VALUE_W-1:0] wide;
      int nr;
      int nc;
      bit ok;
      nr = rows_eff();
      nc = cols_eff();
      wide = {{(VALUE_W-ADD_W){v[ADD_W-1]}}, v};
      if (cmd == CMD_QUERY) begin
        ok = rl >= 1 && int'(rl) <= nr && cl >= 1 && int'(cl) <= nc;
        res.sum = ok ? descend_sum(int'(rl), int'(cl)) : '0;
        res.err = !ok;
        pending.push_back(res);
      end else begin
        ok = rl >= 1 && cl >= 1 && rl <= rh && cl <= ch && int'(rh) <= nr && int'(ch) <= nc;
        if (!ok) begin
          res.sum = '0;
          res.err = 1'b1;
          pending.push_back(res);
        end else begin
          climb_add(int'(rl), int'(cl), wide);
          climb_add(int'(rl), int'(ch) + 1, '0 - wide);
          climb_add(int'(rh) + 1, int'(cl), '0 - wide);
          climb_add(int'(rh) + 1, int'(ch) + 1, wide);
        end
      end
    endfunction

    function void match_result(logic [VALUE_W-1:0] got_sum, logic got_err);
      point_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: point_value %0d range_error %0b", $signed(got_sum), got_err);
        fails++;
        return;
      end
      want = pending.pop_front();
      if (got_sum !== want.sum) begin
        $error("point_value: expected %0d, got %0d", $signed(want.sum), $signed(got_sum));
        fails++;
      end
      if (got_err !== want.err) begin
        $error("range_error: expected %0b, got %0b", want.err, got_err);
        fails++;
      end
    endfunction
  endclass

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic                      command;
  logic [COORD_W-1:0]        row_low;
  logic [COORD_W-1:0]        col_low;
  logic [COORD_W-1:0]        row_high;
  logic [COORD_W-1:0]        col_high;
  logic signed [ADD_W-1:0]   add_value;
  logic                      done;
  logic signed [VALUE_W-1:0] point_value;
  logic                      range_error;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [2:0]                paddr;
  logic [31:0]               pwdata;
  logic [31:0]               prdata;
  logic                      pready;

  grid_ledger board;
  int idle_pct;
  int cycles;

  // Grid settings per phase: reset size, clamped sizes, the minimum, zero, odd sizes.
  int phase_rows  [NUM_PHASES] = '{64, 127, 1, 0, 13, 5, 64};
  int phase_cols  [NUM_PHASES] = '{64, 100, 1, 9, 64, 0, 64};
  int phase_idle  [NUM_PHASES] = '{0, 84, 28, 0, 84, 28, 84};
  int phase_items [NUM_PHASES] = '{450, 300, 150, 60, 300, 60, 380};

  fenwick_2d_range_add_point_query u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .command     (command),
    .row_low     (row_low),
    .col_low     (col_low),
    .row_high    (row_high),
    .col_high    (col_high),
    .add_value   (add_value),
    .done        (done),
    .point_value (point_value),
    .range_error (range_error),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Abort a hung run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Check results before noting a new item, so a stray result cannot pair
  // with an item taken at the same edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (done) board.match_result(point_value, range_error);
      if (start && !busy)
        board.take_item(command, row_low, col_low, row_high, col_high, add_value);
    end
  end

  // Present one item and hold it until taken; then maybe go idle for a while.
  task automatic send_item(logic cmd, logic [COORD_W-1:0] rl, logic [COORD_W-1:0] cl,
                           logic [COORD_W-1:0] rh, logic [COORD_W-1:0] ch,
                           logic [ADD_W-1:0] v);
    command   <= cmd;
    row_low   <= rl;
    col_low   <= cl;
    row_high  <= rh;
    col_high  <= ch;
    add_value <= v;
    start     <= 1'b1;
    do @(posedge clk); while (busy);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Drop start and wait until every owed result is in.
  task automatic wait_results();
    start <= 1'b0;
    do @(posedge clk); while (board.pending.size() != 0);
  endtask

  // Bring the block to rest: an accepted add owes no result, so also wait
  // out its longest walk.
  task automatic drain();
    wait_results();
    repeat (LATENCY_PAUSE) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Write a register, then read it straight back in a back-to-back transfer.
  task automatic write_reg(logic idx, logic [COORD_W-1:0] val);
    logic [31:0] junk;
    logic [31:0] seen;
    junk = $urandom();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {junk[31:COORD_W], val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    board.set_grid(idx, val);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    seen = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (seen !== {{(32-COORD_W){1'b0}}, val}) begin
      $error("prdata: expected %0d, got %0d", val, seen);
      board.fails++;
    end
  endtask

  // Mostly well-formed commands inside the grid; some pinned to its edges,
  // the rest raw noise over the whole field range.
  task automatic random_item();
    int nr;
    int nc;
    int pick;
    logic cmd;
    logic [COORD_W-1:0] rl;
    logic [COORD_W-1:0] cl;
    logic [COORD_W-1:0] rh;
    logic [COORD_W-1:0] ch;
    logic [COORD_W-1:0] t;
    logic [ADD_W-1:0] v;
    nr = board.rows_eff();
    nc = board.cols_eff();
    cmd = $urandom_range(1) ? CMD_ADD : CMD_QUERY;
    rl = COORD_W'($urandom());
    cl = COORD_W'($urandom());
    rh = COORD_W'($urandom());
    ch = COORD_W'($urandom());
    pick = $urandom_range(99);
    if (nr > 0 && nc > 0 && pick >= 15) begin
      rl = COORD_W'($urandom_range(1, nr));
      rh = COORD_W'($urandom_range(1, nr));
      cl = COORD_W'($urandom_range(1, nc));
      ch = COORD_W'($urandom_range(1, nc));
      if (rl > rh) begin
        t = rl; rl = rh; rh = t;
      end
      if (cl > ch) begin
        t = cl; cl = ch; ch = t;
      end
      if (pick < 27) begin
        case ($urandom_range(3))
          0: begin
            rl = 1; cl = 1;
          end
          1: begin
            rl = COORD_W'(nr); rh = COORD_W'(nr); cl = COORD_W'(nc); ch = COORD_W'(nc);
          end
          2: begin
            rh = COORD_W'(nr); ch = COORD_W'(nc);
          end
          default: begin
            // one past the grid edge
            if ($urandom_range(1)) begin
              rl = COORD_W'(nr + 1); rh = COORD_W'(nr + 1);
            end else begin
              cl = COORD_W'(nc + 1); ch = COORD_W'(nc + 1);
            end
          end
        endcase
      end
    end
    case ($urandom_range(9))
      0:       v = 32'h7fff_ffff;
      1:       v = 32'h8000_0000;
      2:       v = 32'hffff_ffff;
      3, 4:    v = $urandom();
      default: v = $urandom_range(2000) - 1000;
    endcase
    send_item(cmd, rl, cl, rh, ch, v);
  endtask

  initial begin
    board = new();
    cycles = 0;
    idle_pct = 0;
    rst = 1'b1;
    start = 1'b0;
    command = CMD_QUERY;
    row_low = '0;
    col_low = '0;
    row_high = '0;
    col_high = '0;
    add_value = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // Hold off until the clearing pass is over.
    do @(posedge clk); while (busy);

    // Directed part at the reset grid of 64 x 64.
    send_item(CMD_QUERY, 1, 1, 0, 0, 0);
    send_item(CMD_ADD, 1, 1, 64, 64, 32'h7fff_ffff);
    send_item(CMD_ADD, 1, 1, 1, 1, 32'h8000_0000);
    send_item(CMD_ADD, 64, 64, 64, 64, 32'hffff_ffff);
    send_item(CMD_ADD, 2, 3, 40, 50, 12345);
    send_item(CMD_ADD, 33, 17, 33, 17, -7);
    send_item(CMD_QUERY, 1, 1, 0, 0, 0);
    send_item(CMD_QUERY, 64, 64, 0, 0, 0);
    send_item(CMD_QUERY, 64, 1, 0, 0, 0);
    send_item(CMD_QUERY, 1, 64, 0, 0, 0);
    send_item(CMD_QUERY, 33, 17, 0, 0, 0);
    send_item(CMD_QUERY, 40, 50, 0, 0, 0);
    send_item(CMD_QUERY, 41, 51, 0, 0, 0);
    // bad query points
    send_item(CMD_QUERY, 0, 5, 0, 0, 0);
    send_item(CMD_QUERY, 65, 1, 0, 0, 0);
    send_item(CMD_QUERY, 1, 127, 0, 0, 0);
    send_item(CMD_QUERY, 127, 127, 127, 127, 32'hffff_ffff);
    // bad rectangles: reversed, below one, beyond the grid
    send_item(CMD_ADD, 10, 1, 9, 5, 99);
    send_item(CMD_ADD, 1, 10, 5, 9, 99);
    send_item(CMD_ADD, 1, 1, 65, 5, 99);
    send_item(CMD_ADD, 0, 1, 5, 5, 99);
    send_item(CMD_ADD, 1, 1, 5, 127, 99);
    send_item(CMD_ADD, 1, 1, 64, 64, 32'h8000_0000);
    send_item(CMD_QUERY, 32, 32, 0, 0, 0);
    drain();

    // Random phases, each at its own grid size and idle rate.
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_ROWS, COORD_W'(phase_rows[p]));
      write_reg(REG_COLS, COORD_W'(phase_cols[p]));
      idle_pct = phase_idle[p];
      for (int n = 0; n < phase_items[p]; n++) begin
        random_item();
        // now and then, pause until the block has caught up
        if ($urandom_range(149) == 0) wait_results();
      end
      drain();
    end

    // Settle, then catch any late or stray result.
    wait_results();
    repeat (LATENCY_PAUSE) @(posedge clk);
    if (board.pending.size() != 0) begin
      $error("%0d expected results never arrived", board.pending.size());
      board.fails++;
    end
    if (board.fails == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
